>>> src/msie_pkg.sv
// Shared types and constants of the MIPS subset instruction executor.
`timescale 1ns / 1ps

package msie_pkg;

	// Primary opcodes, bits 31:26 of the instruction word (the valid bit included).
	localparam logic [5:0] OPC_SPECIAL = 6'd32;
	localparam logic [5:0] OPC_MUL     = 6'd60;
	localparam logic [5:0] OPC_ADDI    = 6'd40;
	localparam logic [5:0] OPC_LW      = 6'd35;
	localparam logic [5:0] OPC_SW      = 6'd43;
	localparam logic [5:0] OPC_BEQ     = 6'd36;
	localparam logic [5:0] OPC_BLTZ    = 6'd33;
	localparam logic [5:0] OPC_J       = 6'd34;

	// Function codes of the special group, bits 5:0.
	localparam logic [5:0] FN_ADD   = 6'd32;
	localparam logic [5:0] FN_SUB   = 6'd34;
	localparam logic [5:0] FN_AND   = 6'd36;
	localparam logic [5:0] FN_OR    = 6'd37;
	localparam logic [5:0] FN_MOVZ  = 6'd10;
	localparam logic [5:0] FN_SLL   = 6'd0;
	localparam logic [5:0] FN_SRL   = 6'd2;
	localparam logic [5:0] FN_JR    = 6'd8;
	localparam logic [5:0] FN_BREAK = 6'd13;

	// Result status codes.
	localparam logic [2:0] ST_EXECUTED = 3'd0;
	localparam logic [2:0] ST_NOP      = 3'd1;
	localparam logic [2:0] ST_INVALID  = 3'd2;
	localparam logic [2:0] ST_BREAK    = 3'd3;
	localparam logic [2:0] ST_UNKNOWN  = 3'd4;
	localparam logic [2:0] ST_PRELOAD  = 3'd5;

	// Outcome of one executed item, handed from the execute stage to the next.
	typedef struct packed {
		logic [15:0] next_pc;
		logic [2:0]  status;
		logic        taken;
		logic        rw;
		logic [4:0]  ridx;
		logic [31:0] rval;
		logic        load;
		logic        mw;
		logic [31:0] mem_word;
		logic [31:0] mval;
	} msie_exec_t;

endpackage

>>> src/msie_ram.sv
// Generic single write port RAM with one registered, write-first read port.
`timescale 1ns / 1ps

module msie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, and a read that sees a write to the same address in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/msie_regfile.sv
// Register file: two read ports, one write port, entries read as zero until written.
`timescale 1ns / 1ps

module msie_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        re,
	input  logic [4:0]  raddr_a,
	input  logic [4:0]  raddr_b,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b
);

	logic [31:0] vld_q;
	logic        vld_a_q;
	logic        vld_b_q;
	logic [31:0] ram_a;
	logic [31:0] ram_b;

	// Both copies take every write so that each can serve one read address.
	msie_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_a),
		.rdata (ram_a)
	);

	msie_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_b),
		.rdata (ram_b)
	);

	// Written marks: reset clears them, so an unwritten register reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_a_q <= (we && (waddr == raddr_a)) ? 1'b1 : vld_q[raddr_a];
				vld_b_q <= (we && (waddr == raddr_b)) ? 1'b1 : vld_q[raddr_b];
			end
		end
	end

	assign rdata_a = vld_a_q ? ram_a : 32'd0;
	assign rdata_b = vld_b_q ? ram_b : 32'd0;

endmodule

>>> src/msie_exec.sv
// Decode and execute logic for one instruction or preload word.
`timescale 1ns / 1ps

module msie_exec
	import msie_pkg::*;
(
	input  logic        op,
	input  logic [31:0] instr,
	input  logic [15:0] pc,
	input  logic [7:0]  load_index,
	input  logic [31:0] load_value,
	input  logic [31:0] rs_val,
	input  logic [31:0] rt_val,
	output msie_exec_t  res
);

	logic [5:0]  opc;
	logic [5:0]  fn;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sa;
	logic [31:0] simm;
	logic [31:0] addr_sum;
	logic [31:0] product;
	logic [15:0] seq_pc;
	logic [15:0] br_target;

	assign opc       = instr[31:26];
	assign fn        = instr[5:0];
	assign rt        = instr[20:16];
	assign rd        = instr[15:11];
	assign sa        = instr[10:6];
	assign simm      = {{16{instr[15]}}, instr[15:0]};
	assign addr_sum  = rs_val + simm;
	assign product   = rs_val * rt_val;
	assign seq_pc    = pc + 16'd4;
	assign br_target = seq_pc + {simm[13:0], 2'b00};

	// Decode the word and pick the single effect it has.
	always_comb begin
		res          = '0;
		res.next_pc  = seq_pc;
		res.status   = ST_EXECUTED;
		res.mem_word = {2'b00, addr_sum[31:2]};
		if (op) begin
			res.next_pc  = 16'd0;
			res.status   = ST_PRELOAD;
			res.mw       = 1'b1;
			res.mem_word = {24'd0, load_index};
			res.mval     = load_value;
		end else if (!instr[31]) begin
			res.status = ST_INVALID;
		end else if (instr[30:0] == 31'd0) begin
			res.status = ST_NOP;
		end else begin
			case (opc)
				OPC_SPECIAL: begin
					case (fn)
						FN_ADD: begin
							res.rw   = 1'b1;
							res.ridx = rd;
							res.rval = rs_val + rt_val;
						end
						FN_SUB: begin
							res.rw   = 1'b1;
							res.ridx = rd;
							res.rval = rs_val - rt_val;
						end
						FN_AND: begin
							res.rw   = 1'b1;
							res.ridx = rd;
							res.rval = rs_val & rt_val;
						end
						FN_OR: begin
							res.rw   = 1'b1;
							res.ridx = rd;
							res.rval = rs_val | rt_val;
						end
						FN_MOVZ: begin
							if (rt_val == 32'd0) begin
								res.rw   = 1'b1;
								res.ridx = rd;
								res.rval = rs_val;
							end
						end
						FN_SLL: begin
							res.rw   = 1'b1;
							res.ridx = rd;
							res.rval = rt_val << sa;
						end
						FN_SRL: begin
							res.rw   = 1'b1;
							res.ridx = rd;
							res.rval = rt_val >> sa;
						end
						FN_JR: begin
							res.next_pc = rs_val[15:0];
							res.taken   = 1'b1;
						end
						FN_BREAK: begin
							res.status = ST_BREAK;
						end
						default: begin
							res.status = ST_UNKNOWN;
						end
					endcase
				end
				OPC_MUL: begin
					res.rw   = 1'b1;
					res.ridx = rd;
					res.rval = product;
				end
				OPC_ADDI: begin
					res.rw   = 1'b1;
					res.ridx = rt;
					res.rval = addr_sum;
				end
				OPC_LW: begin
					// The loaded word arrives one stage later from data memory.
					res.rw   = 1'b1;
					res.ridx = rt;
					res.load = 1'b1;
				end
				OPC_SW: begin
					res.mw   = 1'b1;
					res.mval = rt_val;
				end
				OPC_BEQ: begin
					if (rs_val == rt_val) begin
						res.next_pc = br_target;
						res.taken   = 1'b1;
					end
				end
				OPC_BLTZ: begin
					if (rs_val[31]) begin
						res.next_pc = br_target;
						res.taken   = 1'b1;
					end
				end
				OPC_J: begin
					res.next_pc = {instr[13:0], 2'b00};
					res.taken   = 1'b1;
				end
				default: begin
					res.status = ST_UNKNOWN;
				end
			endcase
		end
	end

endmodule

>>> src/mips_subset_instruction_executor.sv
// Usage notes:
// Input words arrive on the s_ channel: s_tuser selects execute (0) or data
// memory preload (1), s_tdata carries the instruction, its pc and the preload
// index and value. Each word gives exactly one result word on the m_ channel,
// with the status in m_tuser and the next pc and write reports in m_tdata.
// A word passes from stage one through stage two into the output register;
// one word can be accepted in every cycle while s_tready is high. Stage one
// holds the accepted word while the register file read completes and the
// instruction executes, with the result of the word ahead forwarded into it;
// stage two holds the data memory read of a load; the output register follows.
// A stalled receiver first fills the bubbles of the pipeline, and the input
// side only drops s_tready once stage one, stage two and the output
// register all hold words. After reset all registers read as zero and the
// pipeline is empty; data memory is not cleared, so there is no clearing pass.
// DMEM_WORDS must be a power of two; memory indices wrap modulo its value.
`timescale 1ns / 1ps

module mips_subset_instruction_executor
	import msie_pkg::*;
#(
	parameter int DMEM_WORDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// instr [31:0], pc [47:32], load_index [55:48], load_value [87:56]
	input  logic [87:0] s_tdata,
	// op [0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_pc [15:0], branch_taken [16], reg_written [17], reg_index [22:18],
	// reg_value [54:23], mem_written [55], mem_index [63:56], mem_value [95:64]
	output logic [95:0] m_tdata,
	// status [2:0]
	output logic [2:0]  m_tuser
);

	localparam int DMEM_AW = $clog2(DMEM_WORDS);

	// Stage one: the accepted word.
	logic        v_s1;
	logic        op_s1;
	logic [31:0] instr_s1;
	logic [15:0] pc_s1;
	logic [7:0]  lidx_s1;
	logic [31:0] lval_s1;

	// Stage two: the executed word and its memory index.
	logic        v_s2;
	msie_exec_t  ex_s2;
	logic [7:0]  midx_s2;

	// Output register.
	logic        m_tvalid_q;
	logic [95:0] m_tdata_q;
	logic [2:0]  m_tuser_q;

	logic        out_free;
	logic        s2_free;
	logic        s2_move;
	logic        s1_move;
	logic        accept;

	logic [31:0] raw_a;
	logic [31:0] raw_b;
	logic [31:0] rs_val;
	logic [31:0] rt_val;
	logic        rf_we;
	logic [31:0] rval_s2w;

	msie_exec_t  ex;
	logic [DMEM_AW-1:0] dmem_idx;
	logic [31:0] idx_wide;
	logic        dmem_we;
	logic        dmem_re;
	logic [31:0] dmem_rdata;

	// Stage flow: each stage moves on when the one after it is empty or moving.
	assign out_free = !m_tvalid_q || m_tready;
	assign s2_free  = !v_s2 || out_free;
	assign s2_move  = v_s2 && out_free;
	assign s1_move  = v_s1 && s2_free;
	assign s_tready = !v_s1 || s2_free;
	assign accept   = s_tvalid && s_tready;

	// Register file reads start as the word is accepted.
	msie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (accept),
		.raddr_a (s_tdata[25:21]),
		.raddr_b (s_tdata[20:16]),
		.we      (rf_we),
		.waddr   (ex_s2.ridx),
		.wdata   (rval_s2w),
		.rdata_a (raw_a),
		.rdata_b (raw_b)
	);

	// The word in stage two has not written back yet: forward its value.
	assign rval_s2w = ex_s2.load ? dmem_rdata : ex_s2.rval;
	assign rs_val = (v_s2 && ex_s2.rw && (ex_s2.ridx == instr_s1[25:21])) ? rval_s2w : raw_a;
	assign rt_val = (v_s2 && ex_s2.rw && (ex_s2.ridx == instr_s1[20:16])) ? rval_s2w : raw_b;
	assign rf_we  = s2_move && ex_s2.rw;

	msie_exec u_exec (
		.op         (op_s1),
		.instr      (instr_s1),
		.pc         (pc_s1),
		.load_index (lidx_s1),
		.load_value (lval_s1),
		.rs_val     (rs_val),
		.rt_val     (rt_val),
		.res        (ex)
	);

	// Data memory: stores and preloads write, loads read, as stage one moves on.
	assign dmem_idx = ex.mem_word[DMEM_AW-1:0];
	assign idx_wide = 32'(dmem_idx);
	assign dmem_we  = s1_move && ex.mw;
	assign dmem_re  = s1_move && ex.load;

	msie_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
		.clk   (clk),
		.we    (dmem_we),
		.waddr (dmem_idx),
		.wdata (ex.mval),
		.re    (dmem_re),
		.raddr (dmem_idx),
		.rdata (dmem_rdata)
	);

	// Valid flags of the stages and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				m_tvalid_q <= v_s2;
			end
		end
	end

	// Payload of the stages and the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= s_tuser[0];
			instr_s1 <= s_tdata[31:0];
			pc_s1    <= s_tdata[47:32];
			lidx_s1  <= s_tdata[55:48];
			lval_s1  <= s_tdata[87:56];
		end
		if (s1_move) begin
			ex_s2   <= ex;
			midx_s2 <= ex.mw ? idx_wide[7:0] : 8'd0;
		end
		if (s2_move) begin
			m_tdata_q <= {ex_s2.mval, midx_s2, ex_s2.mw, rval_s2w, ex_s2.ridx,
				ex_s2.rw, ex_s2.taken, ex_s2.next_pc};
			m_tuser_q <= ex_s2.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// The input side only stalls when every stage is full and the receiver holds off.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && m_tvalid && !m_tready))
		else $error("input stalled with room left in the pipeline");

	// A register write-back always goes with a result entering the output register.
	a_writeback_makes_result: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |=> m_tvalid)
		else $error("register written without a result");

	// One data memory access per word: never a read and a write together.
	a_dmem_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(dmem_we && dmem_re))
		else $error("data memory read and written in the same cycle");
`endif

endmodule
